@@ rtl/dctq_pkg.sv @@
package dctq_pkg;

    localparam int BLOCK_EDGE      = 8;
    localparam int NUM_PIX         = BLOCK_EDGE * BLOCK_EDGE;
    localparam int IDX_W           = 6;
    localparam int TABLE_FRAC_BITS = 14;
    localparam int PIX_W           = 8;
    localparam int COEF_W          = 12;
    localparam int QL_W            = 4;
    localparam int BASIS_W         = 32;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIX - 1);

    // cos(k*pi/16), k = 0..8, in Q30
    localparam logic signed [BASIS_W-1:0] COS_Q30 [0:8] = '{
        32'sd1073741824, 32'sd1053110176, 32'sd992008094, 32'sd892783698,
        32'sd759250125,  32'sd596538995,  32'sd410903207, 32'sd209476638,
        32'sd0
    };

    typedef enum logic [1:0] {
        S_COLLECT,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_lane_ctl;

    // Cf * cos((2p+1) f pi / 16) in Q30, with C0 folded in as cos(pi/4)
    function automatic logic signed [BASIS_W-1:0] basis(input logic [2:0] f,
                                                        input logic [2:0] p);
        logic [4:0] kk;
        logic [7:0] prod;
        logic signed [BASIS_W-1:0] res;
        prod = ({4'd0, p, 1'b1}) * {5'd0, f};
        kk   = prod[4:0];
        if (kk > 5'd16) kk = 5'd0 - kk;
        if (f == 3'd0) begin
            res = COS_Q30[4];
        end else if (kk <= 5'd8) begin
            res = COS_Q30[kk[3:0]];
        end else begin
            res = -COS_Q30[4'(5'd16 - kk)];
        end
        return res;
    endfunction

endpackage

@@ rtl/dctq_lane.sv @@
module dctq_lane
    import dctq_pkg::*;
#(
    parameter int FRAC_BITS = TABLE_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic signed [FRAC_BITS-1:0] i_entry,
    input  logic [PIX_W-1:0]         i_pix,
    input  logic [QL_W-1:0]          i_quant_level,
    output logic                     o_q_valid,
    output logic signed [COEF_W-1:0] o_q
);
    localparam int ENT_W = FRAC_BITS;
    localparam int MUL_W = ENT_W + PIX_W + 1;
    localparam int ACC_W = FRAC_BITS + 13;
    localparam int QW    = FRAC_BITS + 17;

    logic signed [MUL_W-1:0] r_mul;
    t_lane_ctl               r_ctl;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_done;
    logic signed [QW-1:0]    n_rnd;
    logic signed [QW-1:0]    n_shr;
    logic [5:0]              n_sh;
    logic signed [COEF_W-1:0] n_q;

    always_comb begin
        n_sh  = 6'(FRAC_BITS) + {2'd0, i_quant_level};
        n_rnd = QW'(r_acc) + (QW'(1) <<< (n_sh - 6'd1));
        n_shr = n_rnd >>> n_sh;
        if (n_shr > QW'(2047)) begin
            n_q = COEF_W'(2047);
        end else if (n_shr < -QW'(2048)) begin
            n_q = -COEF_W'(2048);
        end else begin
            n_q = n_shr[COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= '0;
            r_done    <= 1'b0;
            o_q_valid <= 1'b0;
        end else begin
            r_ctl     <= i_ctl;
            r_done    <= r_ctl.valid && r_ctl.last;
            o_q_valid <= r_done;
        end
        r_mul <= MUL_W'(i_entry) * $signed({1'b0, i_pix});
        if (r_ctl.valid) begin
            r_acc <= r_ctl.first ? ACC_W'(r_mul) : r_acc + ACC_W'(r_mul);
        end
        if (r_done) begin
            o_q <= n_q;
        end
    end
endmodule

@@ rtl/dctq_merge.sv @@
module dctq_merge
    import dctq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic [IDX_W-1:0]         i_idx,
    input  logic signed [COEF_W-1:0] i_q_red,
    input  logic signed [COEF_W-1:0] i_q_green,
    input  logic signed [COEF_W-1:0] i_q_blue,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [COEF_W-1:0] o_coef_red,
    output logic signed [COEF_W-1:0] o_coef_green,
    output logic signed [COEF_W-1:0] o_coef_blue,
    output logic [2:0]               o_freq_u,
    output logic [2:0]               o_freq_v,
    output logic                     o_block_end,
    output logic                     o_any_nonzero,
    output logic [2:0]               o_final_nz_u,
    output logic [2:0]               o_final_nz_v
);
    logic             r_nz_hit;
    logic [IDX_W-1:0] r_nz_idx;
    logic             n_nz_hit;
    logic [IDX_W-1:0] n_nz_idx;
    logic             n_end;

    always_comb begin
        n_nz_hit = (i_idx == '0) ? 1'b0 : r_nz_hit;
        n_nz_idx = (i_idx == '0) ? '0 : r_nz_idx;
        if (i_q_red != '0 || i_q_green != '0 || i_q_blue != '0) begin
            n_nz_hit = 1'b1;
            n_nz_idx = i_idx;
        end
        n_end = (i_idx == LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
            r_nz_hit    <= 1'b0;
            r_nz_idx    <= '0;
        end else if (i_load) begin
            o_out_valid <= 1'b1;
            r_nz_hit    <= n_nz_hit;
            r_nz_idx    <= n_nz_idx;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
        if (i_load) begin
            o_coef_red    <= i_q_red;
            o_coef_green  <= i_q_green;
            o_coef_blue   <= i_q_blue;
            o_freq_u      <= i_idx[2:0];
            o_freq_v      <= i_idx[5:3];
            o_block_end   <= n_end;
            o_any_nonzero <= n_end && n_nz_hit;
            o_final_nz_u  <= (n_end && n_nz_hit) ? n_nz_idx[2:0] : 3'd0;
            o_final_nz_v  <= (n_end && n_nz_hit) ? n_nz_idx[5:3] : 3'd0;
        end
    end
endmodule

@@ rtl/dct8x8_forward_quantize_top.sv @@
// Flow: the 64th pixel of a block starts the transform; the coefficient triples follow
//   in order, each loaded to the output before the terms of the next one are issued.
// Throughput: one table product per cycle while issuing, shared across the three channel
//   lanes; pipeline drain, output stalls and pixel collection come on top of that.
// Reset: synchronous, active low; clears pixel count, FSM, quant_level and valids.
// The pixel buffer has no reset; every entry is written before it is read.
module dct8x8_forward_quantize_top
    import dctq_pkg::*;
#(
    parameter int FRAC_BITS = TABLE_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [QL_W-1:0]          i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [PIX_W-1:0]         i_red,
    input  logic [PIX_W-1:0]         i_green,
    input  logic [PIX_W-1:0]         i_blue,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [COEF_W-1:0] o_coef_red,
    output logic signed [COEF_W-1:0] o_coef_green,
    output logic signed [COEF_W-1:0] o_coef_blue,
    output logic [2:0]               o_freq_u,
    output logic [2:0]               o_freq_v,
    output logic                     o_block_end,
    output logic                     o_any_nonzero,
    output logic [2:0]               o_final_nz_u,
    output logic [2:0]               o_final_nz_v
);
    localparam int ENT_W  = FRAC_BITS;
    localparam int PROD_W = 2 * BASIS_W;
    localparam int SHIFT  = 62 - FRAC_BITS;

    // Pixel buffer, red<<16 | green<<8 | blue
    logic [3*PIX_W-1:0] r_mem [0:NUM_PIX-1];

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;     // pixel index while collecting, term while issuing
    logic [IDX_W-1:0] r_k, n_k;         // coefficient index, u inner
    logic [QL_W-1:0]  r_quant_level;

    // Table entry pipeline
    logic signed [BASIS_W-1:0] r_bu, r_bv;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ENT_W-1:0]   r_ent;
    logic [3*PIX_W-1:0]        r_pix1, r_pix2, r_pix3;
    t_lane_ctl                 r_c1, r_c2, r_c3, n_c0;

    logic [PROD_W-1:0] n_mag, n_rnd;
    logic [ENT_W-1:0]  n_ent_mag;

    logic                     q_valid_r, q_valid_g, q_valid_b;
    logic signed [COEF_W-1:0] q_red, q_green, q_blue;
    logic                     load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_level <= '0;
        end else if (i_cfg_we) begin
            r_quant_level <= i_cfg_data;
        end
    end

    // Sequencer: collect 64 pixels, then run 64 terms per coefficient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_k        = r_k;
        o_in_ready = 1'b0;
        load       = 1'b0;
        n_c0       = '0;
        case (r_state)
            S_COLLECT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        n_state = S_ISSUE;
                        n_k     = '0;
                    end
                end
            end
            S_ISSUE: begin
                n_c0.valid = 1'b1;
                n_c0.first = (r_cnt == '0);
                n_c0.last  = (r_cnt == LAST_IDX);
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (q_valid_r && q_valid_g && q_valid_b) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!o_out_valid || i_out_ready) begin
                    load = 1'b1;
                    n_k  = r_k + 1'b1;
                    n_state = (r_k == LAST_IDX) ? S_COLLECT : S_ISSUE;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    // Buffer write while collecting, registered read while issuing
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mem[r_cnt] <= {i_red, i_green, i_blue};
        end
        r_pix1 <= r_mem[r_cnt];
    end

    // Entry rounding: nearest, ties away from zero
    always_comb begin
        n_mag     = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        n_rnd     = (n_mag + (PROD_W'(1) << (SHIFT - 1))) >> SHIFT;
        n_ent_mag = n_rnd[ENT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else begin
            r_c1 <= n_c0;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
        r_bu   <= basis(r_k[2:0], r_cnt[2:0]);
        r_bv   <= basis(r_k[5:3], r_cnt[5:3]);
        r_prod <= PROD_W'(r_bu) * PROD_W'(r_bv);
        r_pix2 <= r_pix1;
        r_ent  <= r_prod[PROD_W-1] ? -$signed(n_ent_mag) : $signed(n_ent_mag);
        r_pix3 <= r_pix2;
    end

    dctq_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(r_c3), .i_entry(r_ent),
        .i_pix(r_pix3[23:16]), .i_quant_level(r_quant_level),
        .o_q_valid(q_valid_r), .o_q(q_red)
    );

    dctq_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_green (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(r_c3), .i_entry(r_ent),
        .i_pix(r_pix3[15:8]), .i_quant_level(r_quant_level),
        .o_q_valid(q_valid_g), .o_q(q_green)
    );

    dctq_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_blue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(r_c3), .i_entry(r_ent),
        .i_pix(r_pix3[7:0]), .i_quant_level(r_quant_level),
        .o_q_valid(q_valid_b), .o_q(q_blue)
    );

    // Merge the three channels, track the last nonzero position, drive the output
    dctq_merge u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(load), .i_idx(r_k),
        .i_q_red(q_red), .i_q_green(q_green), .i_q_blue(q_blue),
        .i_out_ready(i_out_ready), .o_out_valid(o_out_valid),
        .o_coef_red(o_coef_red), .o_coef_green(o_coef_green),
        .o_coef_blue(o_coef_blue), .o_freq_u(o_freq_u), .o_freq_v(o_freq_v),
        .o_block_end(o_block_end), .o_any_nonzero(o_any_nonzero),
        .o_final_nz_u(o_final_nz_u), .o_final_nz_v(o_final_nz_v)
    );
endmodule

@@ rtl/dctq_checker.sv @@
module dctq_checker
    import dctq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [COEF_W-1:0] o_coef_red,
    input logic [2:0]               o_freq_u,
    input logic [2:0]               o_freq_v,
    input logic                     o_block_end,
    input logic                     o_any_nonzero,
    input logic [2:0]               o_final_nz_u,
    input logic [2:0]               o_final_nz_v
);
    a_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_block_end |-> o_freq_u == 3'd7 && o_freq_v == 3'd7)
        else $error("block end away from the last frequency");

    a_mid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_block_end |->
            !o_any_nonzero && o_final_nz_u == 3'd0 && o_final_nz_v == 3'd0)
        else $error("end-of-block status on a middle transaction");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_any_nonzero |-> o_final_nz_u == 3'd0 && o_final_nz_v == 3'd0)
        else $error("last nonzero position without a nonzero coefficient");

    a_no_pixels_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_block_end |-> !o_in_ready)
        else $error("pixel accepted while a block is still being emitted");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_coef_red))
        else $error("stalled output transaction changed");
endmodule

bind dct8x8_forward_quantize_top dctq_checker u_dctq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_coef_red(o_coef_red), .o_freq_u(o_freq_u), .o_freq_v(o_freq_v),
    .o_block_end(o_block_end), .o_any_nonzero(o_any_nonzero),
    .o_final_nz_u(o_final_nz_u), .o_final_nz_v(o_final_nz_v)
);

@@ sim/tb.sv @@
module tb;
    import dctq_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RAND_BLOCKS  = 1;

    // Pixel patterns for a whole 8x8 block
    typedef enum logic [2:0] {
        PAT_FLAT,
        PAT_CHECKER,
        PAT_RAMP,
        PAT_NOISE,
        PAT_SMOOTH,
        PAT_SPARSE
    } t_pattern;

    // One row of the directed table: a whole block plus the quant level
    typedef struct {
        t_pattern          pat;
        logic [PIX_W-1:0]  a_red, a_green, a_blue;
        logic [PIX_W-1:0]  b_red, b_green, b_blue;
        logic [QL_W-1:0]   quant;
        bit                known;      // DC and end-of-block summary typed in
        logic signed [COEF_W-1:0] dc_red, dc_green, dc_blue;
        logic              nz_any;
    } t_block_row;

    typedef struct {
        logic signed [COEF_W-1:0] red, green, blue;
        logic [2:0]               u, v;
        logic                     last;
        logic                     nz_any;
        logic [2:0]               nz_u, nz_v;
    } t_coef;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [QL_W-1:0]          i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [PIX_W-1:0]         i_red, i_green, i_blue;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [COEF_W-1:0] o_coef_red, o_coef_green, o_coef_blue;
    logic [2:0]               o_freq_u, o_freq_v;
    logic                     o_block_end;
    logic                     o_any_nonzero;
    logic [2:0]               o_final_nz_u, o_final_nz_v;

    dct8x8_forward_quantize_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_coef_red    (o_coef_red),
        .o_coef_green  (o_coef_green),
        .o_coef_blue   (o_coef_blue),
        .o_freq_u      (o_freq_u),
        .o_freq_v      (o_freq_v),
        .o_block_end   (o_block_end),
        .o_any_nonzero (o_any_nonzero),
        .o_final_nz_u  (o_final_nz_u),
        .o_final_nz_v  (o_final_nz_v)
    );

    // cos(k*pi/16), k = 0..8, Q30
    localparam longint COS16 [0:8] = '{
        64'sd1073741824, 64'sd1053110176, 64'sd992008094, 64'sd892783698,
        64'sd759250125,  64'sd596538995,  64'sd410903207, 64'sd209476638, 64'sd0
    };

    // Predictor copy of the block's state
    logic [PIX_W-1:0] blk_red [NUM_PIX];
    logic [PIX_W-1:0] blk_green [NUM_PIX];
    logic [PIX_W-1:0] blk_blue [NUM_PIX];
    logic [IDX_W-1:0] pix_fill;
    logic [QL_W-1:0]  quant_shadow;

    t_coef  coef_queue[$];
    int     errors;
    int     coefs_checked;
    int     blocks_sent;
    int     cycles;
    int     tx_idle_pct;
    int     rx_idle_pct;

    // Clock: free running, 10 time units per cycle
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Scaled basis Cf*cos((2p+1)f*pi/16), Q30; C0 folds to cos(pi/4)
    function automatic longint cos_basis(input int f, input int p);
        int k;
        if (f == 0) return COS16[4];
        k = ((2 * p + 1) * f) & 31;
        if (k > 16) k = 32 - k;
        if (k <= 8) return COS16[k];
        return -COS16[16 - k];
    endfunction

    // Q60 product rounded half away from zero down to the Q14/4 table weight
    function automatic longint dct_weight(input int u, input int v, input int x, input int y);
        longint prod;
        longint mag;
        prod = cos_basis(u, x) * cos_basis(v, y);
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + (64'sd1 <<< 47)) >>> 48;
        return (prod < 0) ? -mag : mag;
    endfunction

    // Divide by 2^(14+q), round half up (floor), saturate to 12 bits
    function automatic logic signed [COEF_W-1:0] quantize_coef(input longint acc,
                                                                input logic [QL_W-1:0] q);
        int     s;
        longint r;
        s = TABLE_FRAC_BITS + int'(q);
        r = (acc + (64'sd1 <<< (s - 1))) >>> s;
        if (r > 2047)  r = 2047;
        if (r < -2048) r = -2048;
        return COEF_W'(r);
    endfunction

    // Transform the buffered block and queue all 64 expected coefficient triples
    task automatic predict_block();
        longint  acc_r, acc_g, acc_b, w;
        t_coef   c;
        bit      seen_nz;
        int      last_u, last_v, p;
        seen_nz = 0;
        last_u  = 0;
        last_v  = 0;
        for (int v = 0; v < BLOCK_EDGE; v++) begin
            for (int u = 0; u < BLOCK_EDGE; u++) begin
                acc_r = 0;
                acc_g = 0;
                acc_b = 0;
                for (int y = 0; y < BLOCK_EDGE; y++) begin
                    for (int x = 0; x < BLOCK_EDGE; x++) begin
                        w = dct_weight(u, v, x, y);
                        p = y * BLOCK_EDGE + x;
                        acc_r += w * longint'(blk_red[p]);
                        acc_g += w * longint'(blk_green[p]);
                        acc_b += w * longint'(blk_blue[p]);
                    end
                end
                c.red    = quantize_coef(acc_r, quant_shadow);
                c.green  = quantize_coef(acc_g, quant_shadow);
                c.blue   = quantize_coef(acc_b, quant_shadow);
                c.u      = 3'(u);
                c.v      = 3'(v);
                c.last   = (u == BLOCK_EDGE - 1) && (v == BLOCK_EDGE - 1);
                if (c.red != 0 || c.green != 0 || c.blue != 0) begin
                    seen_nz = 1;
                    last_u  = u;
                    last_v  = v;
                end
                c.nz_any = c.last && seen_nz;
                c.nz_u   = c.nz_any ? 3'(last_u) : 3'd0;
                c.nz_v   = c.nz_any ? 3'(last_v) : 3'd0;
                coef_queue.push_back(c);
            end
        end
    endtask

    // Receiver: stall at random, decided at the falling edge
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Checker: compare every coefficient transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_coef want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (coef_queue.size() == 0) begin
                report_mismatch("unexpected coefficient, u", o_freq_u, -1);
            end else begin
                want = coef_queue.pop_front();
                coefs_checked++;
                if (o_coef_red !== want.red)
                    report_mismatch("coef_red", o_coef_red, want.red);
                if (o_coef_green !== want.green)
                    report_mismatch("coef_green", o_coef_green, want.green);
                if (o_coef_blue !== want.blue)
                    report_mismatch("coef_blue", o_coef_blue, want.blue);
                if (o_freq_u !== want.u)
                    report_mismatch("freq_u", o_freq_u, want.u);
                if (o_freq_v !== want.v)
                    report_mismatch("freq_v", o_freq_v, want.v);
                if (o_block_end !== want.last)
                    report_mismatch("block_end", o_block_end, want.last);
                if (o_any_nonzero !== want.nz_any)
                    report_mismatch("any_nonzero", o_any_nonzero, want.nz_any);
                if (o_final_nz_u !== want.nz_u)
                    report_mismatch("final_nz_u", o_final_nz_u, want.nz_u);
                if (o_final_nz_v !== want.nz_v)
                    report_mismatch("final_nz_v", o_final_nz_v, want.nz_v);
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("dct8x8_forward_quantize_top: mismatch");
            $finish;
        end
    end

    // Write quant_level; only called while the block is idle
    task automatic write_quant(input logic [QL_W-1:0] q);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= q;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        quant_shadow = q;
    endtask

    // Send one pixel transaction; called at a falling edge, returns at one
    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_red      <= r;
        i_green    <= g;
        i_blue     <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        blk_red[pix_fill]   = r;
        blk_green[pix_fill] = g;
        blk_blue[pix_fill]  = b;
        pix_fill++;
        if (pix_fill == 0) predict_block();
        @(negedge i_clk);
    endtask

    // Per-channel pixel value for a pattern at position (x,y)
    function automatic logic [PIX_W-1:0] pattern_pixel(input t_pattern pat, input int x,
                                                       input int y, input logic [PIX_W-1:0] a,
                                                       input logic [PIX_W-1:0] b);
        case (pat)
            PAT_FLAT:    return a;
            PAT_CHECKER: return ((x ^ y) & 1) ? b : a;
            PAT_RAMP:    return PIX_W'(a + 8'(x * 29) + 8'(y * 3));
            PAT_NOISE:   return PIX_W'($urandom_range(255));
            PAT_SMOOTH:  return PIX_W'(a + 8'(x * b[2:0]) + 8'($urandom_range(3)));
            default:     return ($urandom_range(9) == 0) ? PIX_W'($urandom_range(255)) : a;
        endcase
    endfunction

    // Wait for the block to drain, set the quant level, then stream 64 pixels
    task automatic send_block(input t_pattern pat, input logic [PIX_W-1:0] ar, ag, ab,
                              input logic [PIX_W-1:0] br, bg, bb, input logic [QL_W-1:0] q);
        // Hold off the next block until every coefficient is back
        i_in_valid <= 1'b0;
        wait (coef_queue.size() == 0);
        repeat (8) @(posedge i_clk);
        write_quant(q);
        // Select idle mix by block number: sender light, then receiver light, then none
        if (blocks_sent < 1) begin
            tx_idle_pct = 7;
            rx_idle_pct = 56;
        end else if (blocks_sent < 2) begin
            tx_idle_pct = 56;
            rx_idle_pct = 7;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        for (int p = 0; p < NUM_PIX; p++) begin
            send_pixel(pattern_pixel(pat, p % BLOCK_EDGE, p / BLOCK_EDGE, ar, br),
                       pattern_pixel(pat, p % BLOCK_EDGE, p / BLOCK_EDGE, ag, bg),
                       pattern_pixel(pat, p % BLOCK_EDGE, p / BLOCK_EDGE, ab, bb));
        end
        i_in_valid <= 1'b0;
        blocks_sent++;
    endtask

    // Directed blocks: flat full-scale extreme, checkerboard
    t_block_row directed [2] = '{
        '{PAT_FLAT,    8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   4'd0,
          1, 12'sd2040, 12'sd2040, 12'sd2040, 1'b1},
        '{PAT_CHECKER, 8'd0,   8'd255, 8'd170, 8'd255, 8'd0,   8'd85,  4'd3,
          0, 12'sd0,    12'sd0,    12'sd0,    1'b0}
    };

    initial begin
        t_coef    dc;
        int       qsz;
        t_pattern pat;
        logic [QL_W-1:0] q;

        errors        = 0;
        coefs_checked = 0;
        blocks_sent   = 0;
        cycles        = 0;
        pix_fill      = '0;
        quant_shadow  = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_out_ready   = 1'b0;
        i_red         = '0;
        i_green       = '0;
        i_blue        = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            qsz = coef_queue.size();
            send_block(directed[i].pat, directed[i].a_red, directed[i].a_green,
                       directed[i].a_blue, directed[i].b_red, directed[i].b_green,
                       directed[i].b_blue, directed[i].quant);
            // Override DC and the end summary with the typed-in values
            if (directed[i].known) begin
                dc = coef_queue[qsz];
                dc.red   = directed[i].dc_red;
                dc.green = directed[i].dc_green;
                dc.blue  = directed[i].dc_blue;
                coef_queue[qsz] = dc;
                dc = coef_queue[qsz + NUM_PIX - 1];
                dc.nz_any = directed[i].nz_any;
                dc.nz_u   = 3'd0;
                dc.nz_v   = 3'd0;
                coef_queue[qsz + NUM_PIX - 1] = dc;
            end
        end

        // Random block: a texture from ramp to sparse; quant 15 for the first, 0 for a second, then random
        for (int b = 0; b < RAND_BLOCKS; b++) begin
            pat = t_pattern'($urandom_range(PAT_SPARSE, PAT_RAMP));
            q   = (b == 0) ? 4'd15 : (b == 1) ? 4'd0 : QL_W'($urandom_range(15));
            send_block(pat, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                       PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), q);
        end

        wait (coef_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d blocks (%0d pixels), %0d coefficient triples checked",
                 blocks_sent, blocks_sent * NUM_PIX, coefs_checked);
        $display("quant 0, 3 and 15, flat/checker/random textures, three idle mixes");
        if (errors == 0) begin
            $display("dct8x8_forward_quantize_top: match");
        end else begin
            $display("dct8x8_forward_quantize_top: mismatch");
        end
        $finish;
    end

endmodule

@@ dct8x8_forward_quantize_top.f @@
rtl/dctq_pkg.sv
rtl/dctq_lane.sv
rtl/dctq_merge.sv
rtl/dct8x8_forward_quantize_top.sv
rtl/dctq_checker.sv
sim/tb.sv
